// ===== src/nrs_pkg.sv =====
package nrs_pkg;

  // Value format: signed Q(W-F).F
  localparam int W    = 32;
  localparam int F    = 16;
  localparam int HW   = 16;                 // step size h, unsigned Q0.16
  localparam int CW   = 32;                 // widest configuration register

  localparam int KW   = W + 2;              // k = 2(E - V), signed
  localparam int PMW  = KW - 1 + HW;        // |h2 * k|
  localparam int DG   = (PMW + 7) / 8;      // radix-256 digits of |p|
  localparam int DW12 = DG * 8;
  localparam int AMW  = PMW + 1;            // |a1|, |a2|, |d|
  localparam int MPW  = AMW + HW;           // shared multiplier product
  localparam int NC1  = (W + 1 + HW - 1) / HW;  // 16-bit chunks of |2*y1|
  localparam int NC2  = (W + HW - 1) / HW;      // 16-bit chunks of |y2|
  localparam int Y1W  = NC1 * HW;
  localparam int Y2W  = NC2 * HW;
  localparam int NW   = W + AMW + 3;        // numerator, signed
  localparam int CNTW = $clog2(W);

  typedef enum logic [1:0] {
    REG_ENERGY,
    REG_STEP,
    REG_FIRST,
    REG_SECOND
  } cfg_reg_t;

  localparam logic [W-1:0]   Y_MAX      = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   Y_MIN      = {1'b1, {(W-1){1'b0}}};
  localparam logic [AMW-1:0] ONE_FX     = AMW'(64'd1 << (F + HW));
  localparam logic [HW-1:0]  STEP_RST   = 16'd655;
  localparam logic [W-1:0]   SECOND_RST = 32'd655;

  // One radix-256 digit of a divide by twelve: returns {quotient digit, remainder}.
  function automatic logic [11:0] div12_digit(input logic [3:0] rem_in, input logic [7:0] dig);
    logic [4:0] r;
    logic [7:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[3:0], dig[i]};
      if (r >= 5'd12) begin
        r    = r - 5'd12;
        q[i] = 1'b1;
      end
    end
    return {q, r[3:0]};
  endfunction

  // floor(5 * r / 12) for a remainder r of a divide by twelve
  function automatic logic [2:0] frac5_12(input logic [3:0] r);
    logic [2:0] f;
    case (r) inside
      [4'd0:4'd2]:   f = 3'd0;
      [4'd3:4'd4]:   f = 3'd1;
      [4'd5:4'd7]:   f = 3'd2;
      [4'd8:4'd9]:   f = 3'd3;
      [4'd10:4'd11]: f = 3'd4;
      default:       f = 3'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== src/numerov_recurrence_step.sv =====
// Numerov integrator for the 1-D Schroedinger equation, one wavefunction value per
// potential sample. Each input beat carries a potential sample V (Q16.16); k = 2(E - V).
// The first beat of a run returns start_value_first, the second start_value_second, and
// every later beat returns y = (2*y1*(1 - 5h^2k1/12) - y2*(1 + h^2k2/12)) / (1 + h^2k/12),
// truncated toward zero and saturated to the 32-bit range; a saturation or a zero divisor
// sets the sticky diverged flag until the next run starts. tuser = run_start marks a new
// run, tlast marks the final grid point and is echoed on the result. One item is in work at
// a time. One shared 50x16 multiplier forms h^2 and the three h^2*k products, each product
// is divided by twelve one byte per cycle, the numerator is accumulated in 5 multiply-add
// steps of 16 bits, and a restoring divider retires one quotient bit per cycle. A result that
// saturates before division skips the divider. A result waits in the output register; the
// block holds there while that register is still full. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata; the user must write it only while no item is in work, and the
// block itself does not enforce this.
module numerov_recurrence_step (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_addr,
  input  logic [nrs_pkg::CW-1:0]  cfg_wdata,
  // potential samples
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [nrs_pkg::W-1:0]   in_tdata,   // [31:0] potential
  input  logic                    in_tuser,   // [0] run_start
  input  logic                    in_tlast,   // last_sample
  // wavefunction values
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [nrs_pkg::W-1:0]   out_tdata,  // [31:0] wave_value
  output logic                    out_tuser,  // [0] diverged
  output logic                    out_tlast   // run_end
);

  localparam int W    = nrs_pkg::W;
  localparam int HW   = nrs_pkg::HW;
  localparam int KW   = nrs_pkg::KW;
  localparam int PMW  = nrs_pkg::PMW;
  localparam int DG   = nrs_pkg::DG;
  localparam int DW12 = nrs_pkg::DW12;
  localparam int AMW  = nrs_pkg::AMW;
  localparam int MPW  = nrs_pkg::MPW;
  localparam int NC1  = nrs_pkg::NC1;
  localparam int NC2  = nrs_pkg::NC2;
  localparam int Y1W  = nrs_pkg::Y1W;
  localparam int Y2W  = nrs_pkg::Y2W;
  localparam int NW   = nrs_pkg::NW;
  localparam int CNTW = nrs_pkg::CNTW;
  localparam int NHW  = NW - 1 - W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_H2,
    ST_KABS,
    ST_PMUL,
    ST_D12,
    ST_TERM,
    ST_SUM,
    ST_MAC,
    ST_NABS,
    ST_CHK,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_NEW,
    PH_SECOND,
    PH_REC
  } phase_t;

  typedef enum logic [1:0] {
    TERM_D,
    TERM_A1,
    TERM_A2
  } term_t;

  state_t            state_r;
  phase_t            phase_r;
  term_t             sel_r;
  logic [CNTW-1:0]   cnt_r;

  logic [W-1:0]      energy_r;
  logic [HW-1:0]     step_r;
  logic [W-1:0]      first_r;
  logic [W-1:0]      second_r;

  logic [W-1:0]      wave_prev_r;
  logic [W-1:0]      wave_prev2_r;
  logic [KW-1:0]     kappa_prev_r;
  logic [KW-1:0]     kappa_prev2_r;
  logic [KW-1:0]     k_r;
  logic              diverged_r;
  logic              last_r;

  logic [HW-1:0]     h2_r;
  logic [KW-2:0]     kmag_r;
  logic              ksgn_r;
  logic [DW12-1:0]   dsh_r;
  logic [DW12-1:0]   q12_r;
  logic [3:0]        rem12_r;
  logic [PMW-1:0]    tm_r;
  logic [AMW-1:0]    a1mag_r;
  logic [AMW-1:0]    a2mag_r;
  logic [AMW-1:0]    dmag_r;
  logic              a1neg_r;
  logic              a2neg_r;
  logic              dneg_r;
  logic [Y1W-1:0]    ym1_r;
  logic [Y2W-1:0]    ym2_r;
  logic              y1neg_r;
  logic              y2neg_r;
  logic [NW-1:0]     acc_r;
  logic [NW-2:0]     nmag_r;
  logic              nneg_r;
  logic [AMW-1:0]    rem_r;
  logic [W-1:0]      qsh_r;
  logic [W-1:0]      y_r;

  logic              out_tvalid_r;
  logic [W-1:0]      out_tdata_r;
  logic              out_tuser_r;
  logic              out_tlast_r;

  logic              in_fire;
  logic [W:0]        diff;
  logic [KW-1:0]     k_new;
  logic [KW-1:0]     k_sel;
  logic [KW-1:0]     k_abs;
  logic [W:0]        two_y1;
  logic [W:0]        y1_abs;
  logic [W-1:0]      y2_abs;
  logic [AMW-1:0]    mul_x;
  logic [HW-1:0]     mul_c;
  logic [MPW-1:0]    mul_prod;
  logic [HW-1:0]     mac_chunk;
  logic [NW-1:0]     mac_pp;
  logic              mac_term1;
  logic              mac_sub;
  logic [NW-1:0]     acc_nxt;
  logic [11:0]       d12_res;
  logic [PMW+2:0]    five_q;
  logic [PMW-1:0]    tm_nxt;
  logic [AMW-1:0]    tm_ext;
  logic              sum_sub;
  logic              sum_big;
  logic [AMW-1:0]    sum_mag;
  logic              sum_neg;
  logic [NW-1:0]     acc_abs;
  logic [NHW-1:0]    n_hi;
  logic              chk_ovf;
  logic [AMW:0]      remsh;
  logic [AMW:0]      rem_sub;
  logic              div_ge;
  logic              qneg;
  logic              qovf;
  logic [W-1:0]      fin_y;
  logic              out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_free   = ~out_tvalid_r | out_tready;

  assign diff  = {energy_r[W-1], energy_r} - {in_tdata[W-1], in_tdata};
  assign k_new = {diff, 1'b0};

  always_comb begin
    case (sel_r)
      TERM_D:  k_sel = k_r;
      TERM_A1: k_sel = kappa_prev_r;
      default: k_sel = kappa_prev2_r;
    endcase
  end

  assign k_abs  = k_sel[KW-1] ? (~k_sel + 1'b1) : k_sel;
  assign two_y1 = {wave_prev_r, 1'b0};
  assign y1_abs = two_y1[W] ? (~two_y1 + 1'b1) : two_y1;
  assign y2_abs = wave_prev2_r[W-1] ? (~wave_prev2_r + 1'b1) : wave_prev2_r;

  // chunk of the y magnitude and weight of the partial product for this MAC step
  assign mac_term1 = (cnt_r < CNTW'(NC1));

  always_comb begin
    mac_chunk = '0;
    mac_pp    = '0;
    for (int i = 0; i < NC1; i++) begin
      if (cnt_r == CNTW'(i)) begin
        mac_chunk = ym1_r[i*HW +: HW];
        mac_pp    = NW'(mul_prod) << (i * HW);
      end
    end
    for (int i = 0; i < NC2; i++) begin
      if (cnt_r == CNTW'(NC1 + i)) begin
        mac_chunk = ym2_r[i*HW +: HW];
        mac_pp    = NW'(mul_prod) << (i * HW);
      end
    end
  end

  // shared multiplier
  always_comb begin
    case (state_r)
      ST_H2: begin
        mul_x = AMW'(step_r);
        mul_c = step_r;
      end
      ST_PMUL: begin
        mul_x = AMW'(kmag_r);
        mul_c = h2_r;
      end
      ST_MAC: begin
        mul_x = mac_term1 ? a1mag_r : a2mag_r;
        mul_c = mac_chunk;
      end
      default: begin
        mul_x = '0;
        mul_c = '0;
      end
    endcase
  end

  assign mul_prod = MPW'(mul_x) * MPW'(mul_c);

  // the second product is subtracted, so its sign flips
  assign mac_sub = mac_term1 ? (y1neg_r ^ a1neg_r) : ~(y2neg_r ^ a2neg_r);
  assign acc_nxt = mac_sub ? (acc_r - mac_pp) : (acc_r + mac_pp);

  assign d12_res = nrs_pkg::div12_digit(rem12_r, dsh_r[DW12-1 -: 8]);

  // trunc(5p/12) = 5q + floor(5r/12) with |p| = 12q + r
  assign five_q = (PMW+3)'({q12_r[PMW-1:0], 2'b00}) + (PMW+3)'(q12_r[PMW-1:0])
                + (PMW+3)'(nrs_pkg::frac5_12(rem12_r));
  assign tm_nxt = (sel_r == TERM_A1) ? five_q[PMW-1:0] : q12_r[PMW-1:0];

  // ONE +/- term, kept as sign and magnitude
  assign tm_ext  = AMW'(tm_r);
  assign sum_sub = (sel_r == TERM_A1) ^ ksgn_r;
  assign sum_big = tm_ext > nrs_pkg::ONE_FX;
  assign sum_neg = sum_sub & sum_big;

  always_comb begin
    if (!sum_sub) begin
      sum_mag = tm_ext + nrs_pkg::ONE_FX;
    end else if (sum_big) begin
      sum_mag = tm_ext - nrs_pkg::ONE_FX;
    end else begin
      sum_mag = nrs_pkg::ONE_FX - tm_ext;
    end
  end

  assign acc_abs = acc_r[NW-1] ? (~acc_r + 1'b1) : acc_r;

  // quotient of at least 2^W is out of range before dividing
  assign n_hi    = nmag_r[NW-2:W];
  assign chk_ovf = (n_hi >= NHW'(dmag_r));

  assign remsh   = {rem_r, qsh_r[W-1]};
  assign rem_sub = remsh - {1'b0, dmag_r};
  assign div_ge  = (remsh >= {1'b0, dmag_r});

  assign qneg  = nneg_r ^ dneg_r;
  assign qovf  = qneg ? (qsh_r > nrs_pkg::Y_MIN) : (qsh_r > nrs_pkg::Y_MAX);

  always_comb begin
    if (qovf) begin
      fin_y = qneg ? nrs_pkg::Y_MIN : nrs_pkg::Y_MAX;
    end else if (qneg) begin
      fin_y = ~qsh_r + 1'b1;
    end else begin
      fin_y = qsh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= PH_NEW;
      sel_r         <= TERM_D;
      cnt_r         <= '0;
      energy_r      <= '0;
      step_r        <= nrs_pkg::STEP_RST;
      first_r       <= '0;
      second_r      <= nrs_pkg::SECOND_RST;
      wave_prev_r   <= '0;
      wave_prev2_r  <= '0;
      kappa_prev_r  <= '0;
      kappa_prev2_r <= '0;
      diverged_r    <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (nrs_pkg::cfg_reg_t'(cfg_addr))
          nrs_pkg::REG_ENERGY: energy_r <= cfg_wdata[W-1:0];
          nrs_pkg::REG_STEP:   step_r   <= cfg_wdata[HW-1:0];
          nrs_pkg::REG_FIRST:  first_r  <= cfg_wdata[W-1:0];
          nrs_pkg::REG_SECOND: second_r <= cfg_wdata[W-1:0];
          default: ;
        endcase
      end

      // drop the beat once taken, unless a new one is loaded this cycle
      if (out_tvalid_r && out_tready && state_r != ST_OUT) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            k_r    <= k_new;
            last_r <= in_tlast;
            if (in_tuser || phase_r == PH_NEW) begin
              diverged_r <= 1'b0;
              y_r        <= first_r;
              phase_r    <= in_tlast ? PH_NEW : PH_SECOND;
              state_r    <= ST_OUT;
            end else if (phase_r == PH_SECOND) begin
              y_r     <= second_r;
              phase_r <= in_tlast ? PH_NEW : PH_REC;
              state_r <= ST_OUT;
            end else begin
              phase_r <= in_tlast ? PH_NEW : PH_REC;
              state_r <= ST_H2;
            end
          end
        end
        ST_H2: begin
          h2_r    <= mul_prod[2*HW-1:HW];
          ym1_r   <= Y1W'(y1_abs);
          ym2_r   <= Y2W'(y2_abs);
          y1neg_r <= wave_prev_r[W-1];
          y2neg_r <= wave_prev2_r[W-1];
          acc_r   <= '0;
          sel_r   <= TERM_D;
          state_r <= ST_KABS;
        end
        ST_KABS: begin
          kmag_r  <= k_abs[KW-2:0];
          ksgn_r  <= k_sel[KW-1];
          state_r <= ST_PMUL;
        end
        ST_PMUL: begin
          dsh_r   <= DW12'(mul_prod);
          rem12_r <= '0;
          cnt_r   <= '0;
          state_r <= ST_D12;
        end
        ST_D12: begin
          // one byte of |p| / 12 per step, most significant first
          dsh_r   <= dsh_r << 8;
          q12_r   <= {q12_r[DW12-9:0], d12_res[11:4]};
          rem12_r <= d12_res[3:0];
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(DG - 1)) begin
            state_r <= ST_TERM;
          end
        end
        ST_TERM: begin
          tm_r    <= tm_nxt;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          case (sel_r)
            TERM_D: begin
              dmag_r  <= sum_mag;
              dneg_r  <= sum_neg;
              sel_r   <= TERM_A1;
              state_r <= ST_KABS;
            end
            TERM_A1: begin
              a1mag_r <= sum_mag;
              a1neg_r <= sum_neg;
              sel_r   <= TERM_A2;
              state_r <= ST_KABS;
            end
            default: begin
              a2mag_r <= sum_mag;
              a2neg_r <= sum_neg;
              cnt_r   <= '0;
              state_r <= ST_MAC;
            end
          endcase
        end
        ST_MAC: begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(NC1 + NC2 - 1)) begin
            state_r <= ST_NABS;
          end
        end
        ST_NABS: begin
          nmag_r  <= acc_abs[NW-2:0];
          nneg_r  <= acc_r[NW-1];
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (dmag_r == '0) begin
            diverged_r <= 1'b1;
            y_r        <= nneg_r ? nrs_pkg::Y_MIN : nrs_pkg::Y_MAX;
            state_r    <= ST_OUT;
          end else if (chk_ovf) begin
            diverged_r <= 1'b1;
            y_r        <= qneg ? nrs_pkg::Y_MIN : nrs_pkg::Y_MAX;
            state_r    <= ST_OUT;
          end else begin
            rem_r   <= n_hi[AMW-1:0];
            qsh_r   <= nmag_r[W-1:0];
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per step
          rem_r <= div_ge ? rem_sub[AMW-1:0] : remsh[AMW-1:0];
          qsh_r <= {qsh_r[W-2:0], div_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(W - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          y_r <= fin_y;
          if (qovf) begin
            diverged_r <= 1'b1;
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free, then advance the history
          if (out_free) begin
            out_tvalid_r  <= 1'b1;
            out_tdata_r   <= y_r;
            out_tuser_r   <= diverged_r;
            out_tlast_r   <= last_r;
            wave_prev2_r  <= wave_prev_r;
            wave_prev_r   <= y_r;
            kappa_prev2_r <= kappa_prev_r;
            kappa_prev_r  <= k_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
